/* sv/remappable_byte_bus_defines.svh */
// Assertion macros shared by the bus files.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef REMAPPABLE_BYTE_BUS_DEFINES_SVH
`define REMAPPABLE_BYTE_BUS_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define RBB_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("remappable_byte_bus: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RBB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("remappable_byte_bus: next-cycle check failed");

`else

`define RBB_ASSERT_IMPLIES(label, ante, cons)
`define RBB_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* sv/rbb_pkg.sv */
package rbb_pkg;

	localparam int OP_W   = 3;
	localparam int BUS_AW = 16;
	localparam int OFF_W  = 13;
	localparam int COMP_W = 3;
	localparam int DATA_W = 16;
	localparam int ST_W   = 2;

	typedef enum logic [OP_W-1:0] {
		OP_READ   = 3'd0,
		OP_READ16 = 3'd1,
		OP_WRITE  = 3'd2,
		OP_WRITE16 = 3'd3,
		OP_PLUG   = 3'd4,
		OP_FPLUG  = 3'd5,
		OP_UNPLUG = 3'd6
	} op_e_t;

	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_BAD  = 2'd1;
	localparam logic [ST_W-1:0] ST_ADDR = 2'd2;

	// First field sits in the lowest bits, so it is declared last.
	typedef struct packed {
		logic [DATA_W-1:0] write_data;
		logic [COMP_W-1:0] component;
		logic [OFF_W-1:0]  offset;
		logic [BUS_AW-1:0] end_address;
		logic [BUS_AW-1:0] address;
		logic [OP_W-1:0]   opcode;
	} item_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [DATA_W-1:0] read_data;
	} res_t;

	typedef struct packed {
		logic load;
		logic step;
	} walk_ctl_t;

	localparam int ITEM_W      = $bits(item_t);
	localparam int IN_TDATA_W  = ((ITEM_W + 7) / 8) * 8;
	localparam int RES_W       = $bits(res_t);
	localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

	// Address bits for a store of the given depth, never fewer than one.
	function automatic int idx_bits(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

/* sv/remappable_byte_bus.sv */
// Remappable byte bus: a bus of BUS_BYTES addresses whose map points each
// address at one byte in the memories of NUM_COMPONENTS components.
// Requests arrive on the s_axis channel and every request gives exactly one
// result on the m_axis channel, in order. The block takes one request at a
// time: s_axis_tready is high only while the sequencer is idle.
// Plugs, forced plugs and unplugs of a plugged component walk their range in
// the map: the shared range walker handles one map entry per cycle, and the
// plug scans the range before it fills it. A plug stops its scan at the first
// taken entry in its range.
// The result reaches m_axis at the edge where s_axis_tready rises again.
// After reset the map is cleared, one entry a cycle, and s_axis_tready stays
// low until the clear is done. Component memories are not cleared.
// A finished result goes into the m_axis output register and the block goes
// back to idle at once, so it accepts the next request while that result
// waits. If the receiver is still stalling when the next result is ready, the
// sequencer holds that result and takes no new request until the register
// frees up.
`include "remappable_byte_bus_defines.svh"

module remappable_byte_bus
	import rbb_pkg::*;
#(
	parameter int NUM_COMPONENTS = 8,
	parameter int COMP_MEM_BYTES = 8192,
	parameter int BUS_BYTES      = 65536
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// opcode, address, end_address, offset, component, write_data, zero fill
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// read_data, status, zero fill
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam int ADDR_W    = idx_bits(BUS_BYTES);
	localparam int MEM_TOTAL = NUM_COMPONENTS * COMP_MEM_BYTES;
	localparam int IDX_W     = idx_bits(MEM_TOTAL);
	localparam int MW        = IDX_W + 1;
	localparam int CW        = idx_bits(NUM_COMPONENTS);
	localparam int OUT_PAD   = OUT_TDATA_W - RES_W;

	item_t             in_item;
	logic              in_acc;
	logic              out_valid_q;
	res_t              out_q;
	logic              out_busy;
	logic              res_vld;
	logic              res_take;
	res_t              res;

	logic [ADDR_W-1:0] map_raddr;
	logic [MW-1:0]     map_rdata;
	logic              map_we;
	logic [MW-1:0]     map_wdata;
	logic              mem_we;
	logic [7:0]        mem_wdata;
	logic [7:0]        mem_rdata;
	logic [CW-1:0]     rng_raddr;
	logic [CW-1:0]     rng_waddr;
	logic              rng_we;
	logic [2*ADDR_W-1:0] rng_wdata;
	logic [2*ADDR_W-1:0] rng_rdata;

	walk_ctl_t         wctl;
	logic [ADDR_W-1:0] ld_ptr, ld_end, ptr;
	logic [IDX_W-1:0]  ld_idx, idx;
	logic              at_end;

	// Request fields come straight off tdata; the pad bits above them are ignored.
	assign in_item = item_t'(s_axis_tdata[ITEM_W-1:0]);
	assign in_acc  = s_axis_tvalid && s_axis_tready;

	// The output register is busy when it holds a result that is not taken
	// this cycle; the sequencer must not finish into it then.
	assign out_busy = out_valid_q && !m_axis_tready;
	assign res_take = res_vld && !out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{OUT_PAD{1'b0}}, out_q};

	// Address map: valid bit on top, flat component memory index below.
	// Every map write goes to the walker's current bus address.
	rbb_ram #(
		.WIDTH(MW),
		.DEPTH(BUS_BYTES)
	) u_map (
		.clk  (clk),
		.we   (map_we),
		.waddr(ptr),
		.wdata(map_wdata),
		.raddr(map_raddr),
		.rdata(map_rdata)
	);

	// All component memories live in one byte array. Reads and writes are
	// addressed by the map entry that has just come out of the map.
	rbb_ram #(
		.WIDTH(8),
		.DEPTH(MEM_TOTAL)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(map_rdata[IDX_W-1:0]),
		.wdata(mem_wdata),
		.raddr(map_rdata[IDX_W-1:0]),
		.rdata(mem_rdata)
	);

	// Recorded range of each component, start in the upper half. Whether a
	// range is recorded at all is kept in flops inside the sequencer.
	rbb_ram #(
		.WIDTH(2 * ADDR_W),
		.DEPTH(NUM_COMPONENTS)
	) u_rng (
		.clk  (clk),
		.we   (rng_we),
		.waddr(rng_waddr),
		.wdata(rng_wdata),
		.raddr(rng_raddr),
		.rdata(rng_rdata)
	);

	// Shared range walker: used for the clearing pass, plug scans, map fills
	// and unplug clears.
	rbb_walk #(
		.PW(ADDR_W),
		.IW(IDX_W)
	) u_walk (
		.clk   (clk),
		.ctl   (wctl),
		.ld_ptr(ld_ptr),
		.ld_end(ld_end),
		.ld_idx(ld_idx),
		.ptr   (ptr),
		.idx   (idx),
		.at_end(at_end)
	);

	rbb_seq #(
		.NUM_COMPONENTS(NUM_COMPONENTS),
		.COMP_MEM_BYTES(COMP_MEM_BYTES),
		.BUS_BYTES     (BUS_BYTES)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.in_acc   (in_acc),
		.ready    (s_axis_tready),
		.out_busy (out_busy),
		.res_vld  (res_vld),
		.res      (res),
		.map_raddr(map_raddr),
		.map_rdata(map_rdata),
		.map_we   (map_we),
		.map_wdata(map_wdata),
		.mem_we   (mem_we),
		.mem_wdata(mem_wdata),
		.mem_rdata(mem_rdata),
		.rng_raddr(rng_raddr),
		.rng_waddr(rng_waddr),
		.rng_we   (rng_we),
		.rng_wdata(rng_wdata),
		.rng_rdata(rng_rdata),
		.wctl     (wctl),
		.ld_ptr   (ld_ptr),
		.ld_end   (ld_end),
		.ld_idx   (ld_idx),
		.ptr      (ptr),
		.idx      (idx),
		.at_end   (at_end)
	);

	// Only one request is in the sequencer at a time.
	`RBB_ASSERT_NEXT(a_one_request, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	// The map is never written while the sequencer waits for a request.
	`RBB_ASSERT_IMPLIES(a_no_map_write_idle, s_axis_tready, !map_we)
	// A stalled result in the output register is never overwritten.
	`RBB_ASSERT_IMPLIES(a_no_overrun, m_axis_tvalid && !m_axis_tready, !res_take)

endmodule

/* sv/rbb_ram.sv */
module rbb_ram
	import rbb_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [idx_bits(DEPTH)-1:0]  waddr,
	input  logic [WIDTH-1:0]            wdata,
	input  logic [idx_bits(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/rbb_walk.sv */
module rbb_walk
	import rbb_pkg::*;
#(
	parameter int PW = 16,
	parameter int IW = 16
) (
	input  logic          clk,
	input  walk_ctl_t     ctl,
	input  logic [PW-1:0] ld_ptr,
	input  logic [PW-1:0] ld_end,
	input  logic [IW-1:0] ld_idx,
	output logic [PW-1:0] ptr,
	output logic [IW-1:0] idx,
	output logic          at_end
);

	logic [PW-1:0] ptr_q;
	logic [PW-1:0] end_q;
	logic [IW-1:0] idx_q;

	// The bus pointer and the memory index advance together, one entry a cycle while step is high.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			ptr_q <= ld_ptr;
			end_q <= ld_end;
			idx_q <= ld_idx;
		end else if (ctl.step) begin
			ptr_q <= ptr_q + PW'(1);
			idx_q <= idx_q + IW'(1);
		end
	end

	assign ptr    = ptr_q;
	assign idx    = idx_q;
	assign at_end = (ptr_q == end_q);

endmodule

/* sv/rbb_seq.sv */
module rbb_seq
	import rbb_pkg::*;
#(
	parameter int NUM_COMPONENTS = 8,
	parameter int COMP_MEM_BYTES = 8192,
	parameter int BUS_BYTES      = 65536
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  item_t                                   in_item,
	input  logic                                    in_acc,
	output logic                                    ready,
	input  logic                                    out_busy,
	output logic                                    res_vld,
	output res_t                                    res,
	output logic [idx_bits(BUS_BYTES)-1:0]          map_raddr,
	input  logic [idx_bits(NUM_COMPONENTS * COMP_MEM_BYTES):0] map_rdata,
	output logic                                    map_we,
	output logic [idx_bits(NUM_COMPONENTS * COMP_MEM_BYTES):0] map_wdata,
	output logic                                    mem_we,
	output logic [7:0]                              mem_wdata,
	input  logic [7:0]                              mem_rdata,
	output logic [idx_bits(NUM_COMPONENTS)-1:0]     rng_raddr,
	output logic [idx_bits(NUM_COMPONENTS)-1:0]     rng_waddr,
	output logic                                    rng_we,
	output logic [2*idx_bits(BUS_BYTES)-1:0]        rng_wdata,
	input  logic [2*idx_bits(BUS_BYTES)-1:0]        rng_rdata,
	output walk_ctl_t                               wctl,
	output logic [idx_bits(BUS_BYTES)-1:0]          ld_ptr,
	output logic [idx_bits(BUS_BYTES)-1:0]          ld_end,
	output logic [idx_bits(NUM_COMPONENTS * COMP_MEM_BYTES)-1:0] ld_idx,
	input  logic [idx_bits(BUS_BYTES)-1:0]          ptr,
	input  logic [idx_bits(NUM_COMPONENTS * COMP_MEM_BYTES)-1:0] idx,
	input  logic                                    at_end
);

	localparam int ADDR_W = idx_bits(BUS_BYTES);
	localparam int IDX_W  = idx_bits(NUM_COMPONENTS * COMP_MEM_BYTES);
	localparam int MW     = IDX_W + 1;
	localparam int CW     = idx_bits(NUM_COMPONENTS);
	localparam int RDEPTH = 1 << CW;
	localparam int SPAN_W = BUS_AW + 2;
	localparam logic [BUS_AW:0]   BUS_LIM  = (BUS_AW + 1)'(BUS_BYTES);
	localparam logic [6:0]        NC_LIM   = 7'(NUM_COMPONENTS);
	localparam logic [SPAN_W-1:0] SPAN_LIM = SPAN_W'(COMP_MEM_BYTES);
	localparam logic [ADDR_W-1:0] LAST_A   = ADDR_W'(BUS_BYTES - 1);

	typedef enum logic [3:0] {
		S_INIT_LD,
		S_INIT,
		S_IDLE,
		S_LOOK,
		S_RDB,
		S_R16A,
		S_R16B,
		S_W16,
		S_SCAN,
		S_FILL,
		S_CLR,
		S_HOLD
	} state_t;

	state_t            state_q, nxt;
	item_t             item_q;
	res_t              res_q;
	logic [7:0]        lo_q;
	logic              issue_q, last_q;
	logic [RDEPTH-1:0] rvalid_q;

	logic              fin;
	logic [DATA_W-1:0] fin_rd;
	logic [ST_W-1:0]   fin_st;
	logic              rv_set, rv_clr;
	logic [ADDR_W-1:0] a_t, e_t, next_a;
	logic [CW-1:0]     cidx;
	logic              a_in, a_mapped, e_over, comp_bad, e_zero, span_bad, rng_bad;
	logic [OFF_W-1:0]  plug_off;
	logic [SPAN_W-1:0] span;
	logic [IDX_W-1:0]  base;
	logic              map_vld;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_q <= in_item;
		end
	end

	assign a_t      = ADDR_W'(item_q.address);
	assign e_t      = ADDR_W'(item_q.end_address);
	assign cidx     = CW'(item_q.component);
	assign next_a   = (a_t == LAST_A) ? '0 : a_t + ADDR_W'(1);
	assign map_vld  = map_rdata[MW-1];
	assign a_in     = {1'b0, item_q.address} < BUS_LIM;
	assign a_mapped = a_in && map_vld;
	assign e_over   = {1'b0, item_q.end_address} >= BUS_LIM;
	assign comp_bad = {4'b0, item_q.component} >= NC_LIM;
	assign e_zero   = (item_q.end_address == '0);
	assign plug_off = (item_q.opcode == OP_FPLUG) ? item_q.offset : '0;
	assign span     = SPAN_W'(item_q.end_address) - SPAN_W'(item_q.address)
		+ SPAN_W'(plug_off);
	assign span_bad = span >= SPAN_LIM;
	assign rng_bad  = e_over || (item_q.address > item_q.end_address) || span_bad;
	assign base     = IDX_W'(32'(cidx) * 32'(COMP_MEM_BYTES)) + IDX_W'(plug_off);

	assign ready     = (state_q == S_IDLE);
	assign mem_wdata = (state_q == S_W16) ? item_q.write_data[15:8] : item_q.write_data[7:0];
	assign rng_raddr = (state_q == S_IDLE) ? CW'(in_item.component) : cidx;
	assign rng_waddr = cidx;
	assign rng_wdata = {a_t, e_t};

	always_comb begin
		nxt       = state_q;
		fin       = 1'b0;
		fin_rd    = '0;
		fin_st    = ST_OK;
		wctl      = '0;
		ld_ptr    = a_t;
		ld_end    = e_t;
		ld_idx    = base;
		map_raddr = a_t;
		map_we    = 1'b0;
		map_wdata = '0;
		mem_we    = 1'b0;
		rng_we    = 1'b0;
		rv_set    = 1'b0;
		rv_clr    = 1'b0;
		case (state_q)
			S_INIT_LD: begin
				ld_ptr    = '0;
				ld_end    = LAST_A;
				ld_idx    = '0;
				wctl.load = 1'b1;
				nxt       = S_INIT;
			end
			S_INIT: begin
				map_we    = 1'b1;
				wctl.step = 1'b1;
				if (at_end) begin
					nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				map_raddr = ADDR_W'(in_item.address);
				if (in_acc) begin
					nxt = S_LOOK;
				end
			end
			S_LOOK: begin
				map_raddr = next_a;
				case (item_q.opcode)
					OP_READ: begin
						if (!a_mapped) begin
							fin    = 1'b1;
							fin_rd = 16'h00ff;
						end else begin
							nxt = S_RDB;
						end
					end
					OP_READ16: begin
						if (!a_mapped) begin
							fin    = 1'b1;
							fin_rd = 16'h00ff;
						end else begin
							nxt = S_R16A;
						end
					end
					OP_WRITE: begin
						fin = 1'b1;
						if (!a_mapped) begin
							fin_st = ST_BAD;
						end else begin
							mem_we = 1'b1;
						end
					end
					OP_WRITE16: begin
						if (!a_mapped || item_q.address == '0) begin
							fin    = 1'b1;
							fin_st = ST_BAD;
						end else begin
							mem_we = 1'b1;
							nxt    = S_W16;
						end
					end
					OP_PLUG: begin
						if (comp_bad) begin
							fin    = 1'b1;
							fin_st = ST_BAD;
						end else if (rng_bad) begin
							fin    = 1'b1;
							fin_st = ST_ADDR;
						end else begin
							wctl.load = 1'b1;
							nxt       = S_SCAN;
						end
					end
					OP_FPLUG: begin
						if (comp_bad) begin
							fin    = 1'b1;
							fin_st = ST_BAD;
						end else if (rng_bad) begin
							fin    = 1'b1;
							fin_st = ST_ADDR;
						end else if (e_zero) begin
							rv_clr = 1'b1;
							fin    = 1'b1;
							fin_st = ST_BAD;
						end else begin
							wctl.load = 1'b1;
							nxt       = S_FILL;
						end
					end
					OP_UNPLUG: begin
						if (comp_bad) begin
							fin    = 1'b1;
							fin_st = ST_BAD;
						end else begin
							rv_clr = 1'b1;
							if (rvalid_q[cidx]) begin
								ld_ptr    = rng_rdata[2*ADDR_W-1:ADDR_W];
								ld_end    = rng_rdata[ADDR_W-1:0];
								ld_idx    = '0;
								wctl.load = 1'b1;
								nxt       = S_CLR;
							end else begin
								fin = 1'b1;
							end
						end
					end
					default: begin
						fin    = 1'b1;
						fin_st = ST_BAD;
					end
				endcase
			end
			S_RDB: begin
				fin    = 1'b1;
				fin_rd = {8'h00, mem_rdata};
			end
			S_R16A: begin
				if (map_vld) begin
					nxt = S_R16B;
				end else begin
					fin    = 1'b1;
					fin_rd = {8'hff, mem_rdata};
				end
			end
			S_R16B: begin
				fin    = 1'b1;
				fin_rd = {mem_rdata, lo_q};
			end
			S_W16: begin
				mem_we = map_vld;
				fin    = 1'b1;
			end
			S_SCAN: begin
				map_raddr = ptr;
				if (issue_q && map_vld) begin
					fin    = 1'b1;
					fin_st = ST_ADDR;
				end else if (issue_q && last_q) begin
					if (e_zero) begin
						rv_clr = 1'b1;
						fin    = 1'b1;
						fin_st = ST_BAD;
					end else begin
						wctl.load = 1'b1;
						nxt       = S_FILL;
					end
				end else begin
					wctl.step = 1'b1;
				end
			end
			S_FILL: begin
				map_we    = 1'b1;
				map_wdata = {1'b1, idx};
				wctl.step = 1'b1;
				if (at_end) begin
					rng_we = 1'b1;
					rv_set = 1'b1;
					fin    = 1'b1;
				end
			end
			S_CLR: begin
				map_we    = 1'b1;
				wctl.step = 1'b1;
				if (at_end) begin
					fin = 1'b1;
				end
			end
			S_HOLD: begin
				if (!out_busy) begin
					nxt = S_IDLE;
				end
			end
			default: begin
				nxt = S_IDLE;
			end
		endcase
		if (fin) begin
			nxt = out_busy ? S_HOLD : S_IDLE;
		end
	end

	assign res_vld = fin || (state_q == S_HOLD);
	assign res     = (state_q == S_HOLD) ? res_q : res_t'{status: fin_st, read_data: fin_rd};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT_LD;
			res_q    <= '0;
			lo_q     <= '0;
			issue_q  <= 1'b0;
			last_q   <= 1'b0;
			rvalid_q <= '0;
		end else begin
			state_q <= nxt;
			if (fin && out_busy) begin
				res_q <= '{status: fin_st, read_data: fin_rd};
			end
			if (state_q == S_R16A) begin
				lo_q <= mem_rdata;
			end
			if (state_q == S_SCAN) begin
				if (wctl.step) begin
					issue_q <= 1'b1;
					last_q  <= at_end;
				end
			end else begin
				issue_q <= 1'b0;
				last_q  <= 1'b0;
			end
			if (rv_set) begin
				rvalid_q[cidx] <= 1'b1;
			end else if (rv_clr) begin
				rvalid_q[cidx] <= 1'b0;
			end
		end
	end

endmodule

/* tb/tb_top.sv */
`default_nettype none

// Testbench for remappable_byte_bus.
//
// Every request sent on the s_axis side is run through a local predictor of
// the bus: an address map, the component byte memories and the recorded
// plug range of each component. The predicted result goes into a queue. The
// results on the m_axis side are compared field by field with the oldest
// queued entry.
//
// The test tasks run in turn:
//   test_directed        extremes of the fields, every opcode and the corner
//                        cases (wrapping 16-bit access, partial 16-bit writes,
//                        zero end address, overlap and oversize plugs)
//   test_random_traffic  biased random requests that mostly land in plugged
//                        ranges, with calm stretches where neither side idles
//   test_output_stall    the receiver holds off for a long stretch while the
//                        sender keeps offering requests
//   test_drain_pause     short bursts, with the sender waiting for every
//                        result between bursts
//
// The component memories hold no defined value until written. Reads of mapped
// bytes that were never written are therefore turned into writes before they
// are sent.
module tb_top;
	import rbb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int COMPONENTS   = 8;
	localparam int COMP_BYTES   = 8192;
	localparam int BUS_SIZE     = 65536;
	localparam int MEM_BYTES    = COMPONENTS * COMP_BYTES;
	localparam int CYCLE_LIMIT  = 5000000;
	localparam int TAIL_CYCLES  = 20;
	localparam int LONG_HOLD    = 200;
	localparam int MAX_PRINTED  = 20;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// Predicted bus state, kept in step with every request as it is sent.
	bit        map_valid   [BUS_SIZE];
	bit [15:0] map_idx     [BUS_SIZE];
	bit [7:0]  comp_mem    [MEM_BYTES];
	bit        mem_written [MEM_BYTES];
	bit [15:0] rng_start   [COMPONENTS];
	bit [15:0] rng_end     [COMPONENTS];

	res_t expected_results[$];

	// When set, neither side idles between requests.
	bit calm = 1'b0;
	// A long receiver hold-off, picked up by the receiver process.
	int hold_cycles = 0;

	int unsigned cycle_count = 0;
	int unsigned results_seen = 0;
	int unsigned rejected_count = 0;
	int unsigned mismatch_count = 0;
	int unsigned ops_sent [8];

	remappable_byte_bus #(
		.NUM_COMPONENTS(COMPONENTS),
		.COMP_MEM_BYTES(COMP_BYTES),
		.BUS_BYTES     (BUS_SIZE)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding.",
				cycle_count, expected_results.size());
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// A byte as seen through the map; unmapped addresses float high.
	function automatic bit [7:0] bus_byte(input bit [15:0] a);
		if (!map_valid[a])
			return 8'hff;
		return comp_mem[map_idx[a]];
	endfunction

	function automatic void store_byte(input bit [15:0] a, input bit [7:0] v);
		comp_mem[map_idx[a]] = v;
		mem_written[map_idx[a]] = 1'b1;
	endfunction

	// Maps [s, e] onto the memory of component c from byte off onward.
	function automatic bit [ST_W-1:0] attach_component(input bit [2:0] c,
			input bit [15:0] s, input bit [15:0] e, input bit [12:0] off);
		int i;
		if (s > e || (int'(e) - int'(s) + int'(off)) >= COMP_BYTES)
			return ST_ADDR;
		// A range ending at address zero counts as not plugged.
		if (e == 16'd0) begin
			rng_start[c] = '0;
			rng_end[c] = '0;
			return ST_BAD;
		end
		rng_start[c] = s;
		rng_end[c] = e;
		for (i = 0; i <= int'(e) - int'(s); i++) begin
			map_valid[int'(s) + i] = 1'b1;
			map_idx[int'(s) + i] = 16'(int'(c) * COMP_BYTES + int'(off) + i);
		end
		return ST_OK;
	endfunction

	function automatic res_t predict_bus(input item_t req);
		res_t r;
		bit [15:0] a;
		bit [15:0] nxt;
		bit [2:0] c;
		int i;
		r = '0;
		r.status = ST_OK;
		a = req.address;
		c = req.component;
		// The bus spans the full 16-bit range, so the next address wraps.
		nxt = a + 16'd1;
		case (op_e_t'(req.opcode))
			OP_READ: begin
				r.read_data = {8'h00, bus_byte(a)};
			end
			OP_READ16: begin
				if (!map_valid[a])
					r.read_data = 16'h00ff;
				else
					r.read_data = {bus_byte(nxt), bus_byte(a)};
			end
			OP_WRITE: begin
				if (!map_valid[a])
					r.status = ST_BAD;
				else
					store_byte(a, req.write_data[7:0]);
			end
			OP_WRITE16: begin
				if (a == 16'd0 || !map_valid[a]) begin
					r.status = ST_BAD;
				end else begin
					store_byte(a, req.write_data[7:0]);
					// The high byte is dropped when its address is unmapped.
					if (map_valid[nxt])
						store_byte(nxt, req.write_data[15:8]);
				end
			end
			OP_PLUG: begin
				for (i = int'(a); i <= int'(req.end_address); i++) begin
					if (map_valid[i]) begin
						r.status = ST_ADDR;
						break;
					end
				end
				if (r.status == ST_OK)
					r.status = attach_component(c, a, req.end_address, 13'd0);
			end
			OP_FPLUG: begin
				r.status = attach_component(c, a, req.end_address, req.offset);
			end
			OP_UNPLUG: begin
				if (rng_end[c] != 16'd0) begin
					for (i = int'(rng_start[c]); i <= int'(rng_end[c]); i++)
						map_valid[i] = 1'b0;
				end
				rng_start[c] = '0;
				rng_end[c] = '0;
			end
			default: begin
				r.status = ST_BAD;
			end
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Request generation
	// ------------------------------------------------------------------

	function automatic item_t make_request(input op_e_t op, input bit [15:0] a,
			input bit [15:0] e, input bit [12:0] off, input bit [2:0] c,
			input bit [15:0] wd);
		item_t req;
		req = '0;
		req.opcode = op;
		req.address = a;
		req.end_address = e;
		req.offset = off;
		req.component = c;
		req.write_data = wd;
		return req;
	endfunction

	// Access addresses lean on the plugged ranges (and the byte just past
	// them), then on the low and top windows where plugs are made.
	function automatic bit [15:0] pick_address();
		int k;
		int c;
		k = $urandom_range(0, 99);
		if (k < 60) begin
			c = $urandom_range(0, COMPONENTS - 1);
			if (rng_end[c] != 16'd0)
				return 16'(int'(rng_start[c]) +
					$urandom_range(0, int'(rng_end[c]) - int'(rng_start[c]) + 1));
		end
		if (k < 85)
			return 16'($urandom_range(0, 511));
		if (k < 95)
			return 16'(16'hffff - $urandom_range(0, 255));
		return 16'($urandom());
	endfunction

	function automatic item_t random_request();
		item_t req;
		int k;
		int span;
		req = '0;
		req.write_data = 16'($urandom());
		req.component = 3'($urandom_range(0, COMPONENTS - 1));
		req.offset = 13'($urandom_range(0, COMP_BYTES - 1));
		req.end_address = 16'($urandom());
		k = $urandom_range(0, 99);
		if (k < 22)
			req.opcode = OP_READ;
		else if (k < 40)
			req.opcode = OP_READ16;
		else if (k < 62)
			req.opcode = OP_WRITE;
		else if (k < 80)
			req.opcode = OP_WRITE16;
		else if (k < 88)
			req.opcode = OP_PLUG;
		else if (k < 95)
			req.opcode = OP_FPLUG;
		else
			req.opcode = OP_UNPLUG;

		if (req.opcode == OP_PLUG || req.opcode == OP_FPLUG) begin
			k = $urandom_range(0, 99);
			if (k < 60)
				req.address = 16'($urandom_range(0, 511));
			else if (k < 80)
				req.address = 16'(16'hffff - $urandom_range(0, 63));
			else
				req.address = 16'($urandom());
			// Mostly short ranges, since the block walks them one entry a
			// cycle. A few span up to a whole component, and a few run backward.
			k = $urandom_range(0, 99);
			if (k < 88)
				span = $urandom_range(0, 40);
			else if (k < 94)
				span = $urandom_range(0, COMP_BYTES - 1);
			else
				span = 0 - int'($urandom_range(1, 16));
			req.end_address = req.address + 16'(span);
			// Most forced plugs pick an offset that fits the component memory.
			if (span >= 0 && $urandom_range(0, 4) != 0)
				req.offset = 13'($urandom_range(0, COMP_BYTES - 1 - span));
		end else begin
			req.address = pick_address();
		end
		return req;
	endfunction

	// ------------------------------------------------------------------
	// Sender, receiver and checker
	// ------------------------------------------------------------------

	// Sends one request and returns at the edge where it is accepted. The
	// valid stays high afterward, so the caller either sends again at once
	// or lowers it with settle_bus.
	task automatic send_request(input item_t req);
		bit [15:0] nxt;
		bit defined;
		int gap;
		nxt = req.address + 16'd1;
		// A read that would touch a mapped byte never written turns into a
		// write of the same place.
		if (req.opcode == OP_READ || req.opcode == OP_READ16) begin
			defined = !map_valid[req.address] || mem_written[map_idx[req.address]];
			if (req.opcode == OP_READ16 && map_valid[req.address] &&
					map_valid[nxt] && !mem_written[map_idx[nxt]])
				defined = 1'b0;
			if (!defined)
				req.opcode = (req.address == 16'd0) ? OP_WRITE : OP_WRITE16;
		end
		expected_results.push_back(predict_bus(req));
		ops_sent[req.opcode]++;

		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IN_TDATA_W - ITEM_W){1'b0}}, req};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Drops valid and waits until every outstanding result has arrived.
	task automatic settle_bus();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic report_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED)
			$display("[%0t] result %0d: %s expected 0x%0h, got 0x%0h",
				$realtime, results_seen, what, want, got);
	endtask

	// The receiver draws a stall before each result, or serves a long
	// hold-off when a test asks for one.
	initial begin : receiver
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_cycles > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end else begin
				stall = calm ? 0 : $urandom_range(0, 3);
				if (stall > 0) begin
					m_axis_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	always @(posedge clk) begin : check_results
		res_t got;
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = res_t'(m_axis_tdata[RES_W-1:0]);
			results_seen++;
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing outstanding, read_data",
					0, got.read_data);
			end else begin
				want = expected_results.pop_front();
				if (want.status != ST_OK)
					rejected_count++;
				if (got.read_data !== want.read_data)
					report_mismatch("read_data", want.read_data, got.read_data);
				if (got.status !== want.status)
					report_mismatch("status", want.status, got.status);
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	task automatic test_directed();
		// Everything unmapped: reads float high, writes are refused.
		send_request(make_request(OP_READ,    16'h0000, 16'h0000, 13'h0000, 3'd0, 16'h0000));
		send_request(make_request(OP_READ16,  16'hffff, 16'hffff, 13'h1fff, 3'd7, 16'hffff));
		send_request(make_request(OP_WRITE,   16'h1234, 16'h0000, 13'h0000, 3'd0, 16'h0000));
		send_request(make_request(OP_WRITE16, 16'hffff, 16'h0000, 13'h0000, 3'd0, 16'hffff));
		// Top of the bus onto the last bytes of the last component.
		send_request(make_request(OP_FPLUG,   16'hfff0, 16'hffff, 13'h1ff0, 3'd7, 16'h0000));
		// End address zero, a backward range, and a span one byte too long.
		send_request(make_request(OP_FPLUG,   16'h0000, 16'h0000, 13'h0000, 3'd0, 16'h0000));
		send_request(make_request(OP_FPLUG,   16'h0200, 16'h01ff, 13'h0000, 3'd1, 16'h0000));
		send_request(make_request(OP_FPLUG,   16'h0100, 16'h20ff, 13'h0001, 3'd1, 16'h0000));
		// A whole component memory from address zero.
		send_request(make_request(OP_PLUG,    16'h0000, 16'h1fff, 13'h0000, 3'd2, 16'h0000));
		// A 16-bit write at address zero is refused even when mapped.
		send_request(make_request(OP_WRITE16, 16'h0000, 16'h0000, 13'h0000, 3'd0, 16'hffff));
		send_request(make_request(OP_WRITE,   16'h0000, 16'h0000, 13'h0000, 3'd0, 16'h00a5));
		// 16-bit access across the top of the bus wraps to address zero.
		send_request(make_request(OP_WRITE16, 16'hffff, 16'h0000, 13'h0000, 3'd0, 16'hffff));
		send_request(make_request(OP_READ16,  16'hffff, 16'h0000, 13'h0000, 3'd0, 16'h0000));
		// Plug over a taken range.
		send_request(make_request(OP_PLUG,    16'h1000, 16'h1010, 13'h0000, 3'd3, 16'h0000));
		// Last mapped byte: the high half of the write goes nowhere.
		send_request(make_request(OP_WRITE16, 16'h1fff, 16'h0000, 13'h0000, 3'd0, 16'h5a3c));
		send_request(make_request(OP_READ16,  16'h1fff, 16'h0000, 13'h0000, 3'd0, 16'h0000));
		send_request(make_request(OP_READ,    16'h1fff, 16'h0000, 13'h0000, 3'd0, 16'h0000));
		send_request(make_request(OP_UNPLUG,  16'h0000, 16'h0000, 13'h0000, 3'd2, 16'h0000));
		send_request(make_request(OP_READ,    16'h0000, 16'h0000, 13'h0000, 3'd0, 16'h0000));
		// Unplug of a component that was never plugged.
		send_request(make_request(OP_UNPLUG,  16'h0000, 16'h0000, 13'h0000, 3'd5, 16'h0000));
		// A forced plug takes over entries of another component; unplugging
		// that other component later clears them anyway.
		send_request(make_request(OP_FPLUG,   16'hfff8, 16'hffff, 13'h0000, 3'd4, 16'h0000));
		send_request(make_request(OP_WRITE16, 16'hfffe, 16'h0000, 13'h0000, 3'd0, 16'h1234));
		send_request(make_request(OP_READ16,  16'hfffe, 16'h0000, 13'h0000, 3'd0, 16'h0000));
		send_request(make_request(OP_UNPLUG,  16'h0000, 16'h0000, 13'h0000, 3'd7, 16'h0000));
		send_request(make_request(OP_READ16,  16'hfffe, 16'h0000, 13'h0000, 3'd0, 16'h0000));
		// Plug with end address zero, plug of a backward range.
		send_request(make_request(OP_PLUG,    16'h0000, 16'h0000, 13'h0000, 3'd6, 16'h0000));
		send_request(make_request(OP_PLUG,    16'h0300, 16'h02ff, 13'h0000, 3'd6, 16'h0000));
		// One byte at the highest offset.
		send_request(make_request(OP_FPLUG,   16'h0300, 16'h0300, 13'h1fff, 3'd1, 16'h0000));
		settle_bus();
	endtask

	task automatic test_random_traffic(input int count);
		int n;
		for (n = 0; n < count; n++) begin
			// Every so often switch to a stretch without idle cycles.
			if (n % 60 == 0)
				calm = ($urandom_range(0, 3) == 0);
			send_request(random_request());
		end
		calm = 1'b0;
		settle_bus();
	endtask

	// The receiver stops for a long stretch while requests keep coming, so
	// the output register and the held result fill up and s_axis_tready drops.
	task automatic test_output_stall(input int count);
		int n;
		hold_cycles = LONG_HOLD;
		calm = 1'b1;
		for (n = 0; n < count; n++)
			send_request(random_request());
		calm = 1'b0;
		settle_bus();
	endtask

	// Short bursts; the sender waits for the bus to drain after each one.
	task automatic test_drain_pause(input int bursts, input int burst_len);
		int b;
		int n;
		for (b = 0; b < bursts; b++) begin
			for (n = 0; n < burst_len; n++)
				send_request(random_request());
			settle_bus();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_traffic(950);
		test_output_stall(40);
		test_drain_pause(4, 15);

		repeat (TAIL_CYCLES) @(posedge clk);
		$display({"Sent %0d reads, %0d word reads, %0d writes, %0d word writes, ",
			"%0d plugs, %0d forced plugs, %0d unplugs."},
			ops_sent[OP_READ], ops_sent[OP_READ16], ops_sent[OP_WRITE],
			ops_sent[OP_WRITE16], ops_sent[OP_PLUG], ops_sent[OP_FPLUG],
			ops_sent[OP_UNPLUG]);
		$display({"Checked %0d results (%0d refused), with a long output stall ",
			"and drained bursts; %0d mismatches."},
			results_seen, rejected_count, mismatch_count);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
